// ===== rtl/rmis_pkg.sv =====
// shared types, opcodes and constants for the instruction step block
`default_nettype none
package rmis_pkg;
    localparam int MemWords = 4096;
    localparam int DataBase = 1000;
    localparam int NumRegs = 32;
    localparam logic [4:0] LinkReg = 5'd31;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_DIV = 4'd2, OP_MULT = 4'd3,
        OP_BEQ = 4'd4, OP_BNE = 4'd5, OP_BLEZ = 4'd6, OP_BGTZ = 4'd7,
        OP_J = 4'd8, OP_JAL = 4'd9, OP_JR = 4'd10, OP_LW = 4'd11,
        OP_SW = 4'd12, OP_LI = 4'd13, OP_SRL = 4'd14, OP_SLL = 4'd15
    } t_opcode;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [4:0]         dest_reg;
        logic [4:0]         src_a;
        logic [4:0]         src_b;
        logic signed [31:0] imm_a;
        logic signed [31:0] imm_b;
        logic [4:0]         shift_amount;
        logic [7:0]         cycle_cost;
    } t_in_item;

    typedef struct packed {
        logic [11:0]        next_pc;
        logic               reg_written;
        logic [4:0]         written_reg;
        logic signed [31:0] written_value;
        logic               div_zero;
        logic               mem_error;
        logic [31:0]        cycle_total;
        logic [31:0]        instr_total;
    } t_out_item;

    // divider handshake
    typedef struct packed {
        logic start;
    } t_div_ctl;
endpackage
`default_nettype wire

// ===== rtl/rmis_div.sv =====
// iterative signed divider, one quotient bit per cycle
`default_nettype none
module rmis_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire rmis_pkg::t_div_ctl i_ctl,
    input  wire  [31:0] i_a,
    input  wire  [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_q
);
    logic [31:0] r_rem, n_rem, r_quo, n_quo, r_div, n_div;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg, r_busy, n_busy, r_done, n_done;
    logic [32:0] w_trial;
    logic [31:0] w_rem_sh;

    always_comb begin
        n_rem = r_rem; n_quo = r_quo; n_div = r_div; n_cnt = r_cnt;
        n_neg = r_neg; n_busy = r_busy; n_done = 1'b0;
        w_rem_sh = {r_rem[30:0], r_quo[31]};
        w_trial = {1'b0, w_rem_sh} - {1'b0, r_div};
        if (i_ctl.start) begin
            n_rem = '0;
            n_quo = i_a[31] ? (32'd0 - i_a) : i_a;
            n_div = i_b[31] ? (32'd0 - i_b) : i_b;
            n_neg = i_a[31] ^ i_b[31];
            n_cnt = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_rem_sh;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem; r_quo <= n_quo; r_div <= n_div;
        r_cnt <= n_cnt; r_neg <= n_neg;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_q = r_neg ? (32'd0 - r_quo) : r_quo;
endmodule
`default_nettype wire

// ===== rtl/register_machine_instruction_step_top.sv =====
// top level: sequencer, register file, data store and counters
// states: read, exec, then mem (or the 32-step divider for div), then done
// a new item is taken only after the last one is done; ready only in idle state
// and a result held by the receiver stalls the done state
// lw/sw/jr take register or store reads through registered memory ports
// reset: synchronous active low; then a clearing pass over every store word
// that also clears all the registers at its start, no item taken meanwhile
`default_nettype none
module register_machine_instruction_step_top #(
    parameter int MEM_WORDS = rmis_pkg::MemWords,
    parameter int DATA_BASE = rmis_pkg::DataBase
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire rmis_pkg::t_in_item i_item,
    output logic                o_valid,
    input  wire                 i_ready,
    output rmis_pkg::t_out_item o_item
);
    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_MEM   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    rmis_pkg::t_in_item r_in;
    // register file and data store, registered reads
    logic [31:0] r_regs [rmis_pkg::NumRegs];
    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_va, r_vb, r_vl, r_mdat;
    logic [AW:0] r_clr;
    logic [11:0] r_pc;
    logic [31:0] r_cyc, r_ins;
    logic        r_ovalid;
    rmis_pkg::t_out_item r_out;
    logic [31:0] r_mul;
    // data address, checked wide without overflow
    logic signed [33:0] w_addr;
    logic        w_addr_ok;
    logic [31:0] w_div_q;
    logic        w_div_done;
    rmis_pkg::t_div_ctl w_div_ctl;
    logic [11:0] w_pc1, w_npc;
    logic        w_wr, w_dz, w_me, w_take;
    logic [4:0]  w_wreg;
    logic [31:0] w_wval, w_mag;

    assign w_addr = 34'(r_in.imm_b) + 34'(r_in.imm_a) + 34'(DATA_BASE);
    assign w_addr_ok = !w_addr[33] && (w_addr < 34'(MEM_WORDS));
    assign w_div_ctl.start = (r_state == S_EXEC) &&
        (r_in.opcode == rmis_pkg::OP_DIV) && (r_vb != 32'd0);

    rmis_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_div_ctl),
        .i_a(r_va), .i_b(r_vb), .o_done(w_div_done), .o_q(w_div_q)
    );

    // result of the instruction, formed in the done state
    always_comb begin
        w_pc1 = r_pc + 12'd1;
        w_npc = w_pc1;
        w_wr = 1'b1; w_wreg = r_in.dest_reg; w_wval = '0;
        w_dz = 1'b0; w_me = 1'b0; w_take = 1'b0;
        w_mag = (32'd0 - r_va) >> r_in.shift_amount;
        unique case (r_in.opcode)
            rmis_pkg::OP_ADD:  w_wval = r_va + r_vb;
            rmis_pkg::OP_SUB:  w_wval = r_va - r_vb;
            rmis_pkg::OP_DIV: begin
                w_dz = (r_vb == 32'd0);
                w_wval = w_dz ? 32'd0 : r_mdat;
            end
            rmis_pkg::OP_MULT: w_wval = r_mul;
            rmis_pkg::OP_BEQ:  begin w_wr = 1'b0; w_take = (r_va == r_vb); end
            rmis_pkg::OP_BNE:  begin w_wr = 1'b0; w_take = (r_va != r_vb); end
            rmis_pkg::OP_BLEZ: begin w_wr = 1'b0; w_take = $signed(r_va) <= 0; end
            rmis_pkg::OP_BGTZ: begin w_wr = 1'b0; w_take = $signed(r_va) > 0; end
            rmis_pkg::OP_J:    begin w_wr = 1'b0; w_npc = r_in.imm_a[11:0]; end
            rmis_pkg::OP_JAL: begin
                w_wreg = rmis_pkg::LinkReg;
                w_wval = {20'd0, w_pc1};
                w_npc = r_in.imm_a[11:0];
            end
            rmis_pkg::OP_JR:   begin w_wr = 1'b0; w_npc = r_vl[11:0]; end
            rmis_pkg::OP_LW: begin
                w_wr = w_addr_ok; w_me = !w_addr_ok;
                w_wval = w_addr_ok ? r_mdat : 32'd0;
            end
            rmis_pkg::OP_SW:   begin w_wr = 1'b0; w_me = !w_addr_ok; end
            rmis_pkg::OP_LI:   w_wval = r_in.imm_a;
            rmis_pkg::OP_SRL:
                w_wval = r_va[31] ? (32'd0 - w_mag) : (r_va >> r_in.shift_amount);
            rmis_pkg::OP_SLL:  w_wval = r_va << r_in.shift_amount;
            default: w_wr = 1'b0;
        endcase
        if (w_take) w_npc = w_pc1 + r_in.imm_a[11:0];
        if (!w_wr) begin
            w_wreg = '0;
            w_wval = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr[AW]) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC:  n_state = w_div_ctl.start ? S_DIV : S_MEM;
            S_DIV:   if (w_div_done) n_state = S_DONE;
            S_MEM:   n_state = S_DONE;
            S_DONE:  if (!r_ovalid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    // store: clearing sweep, sw write, lw read; also captures the divider quotient
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR)
            r_mem[r_clr[AW-1:0]] <= '0;
        else if (r_state == S_EXEC && r_in.opcode == rmis_pkg::OP_SW && w_addr_ok)
            r_mem[w_addr[AW-1:0]] <= r_va;
        if (r_state == S_DIV && w_div_done)
            r_mdat <= w_div_q;
        else if (r_state == S_EXEC)
            r_mdat <= r_mem[w_addr[AW-1:0]];
    end

    // register file: clear on sweep, operand reads, write back on done; input and result capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR && !r_clr[AW] && r_clr < (AW+1)'(rmis_pkg::NumRegs))
            r_regs[r_clr[4:0]] <= '0;
        else if (r_state == S_DONE && n_state == S_IDLE && w_wr)
            r_regs[w_wreg] <= w_wval;
        if (r_state == S_READ) begin
            r_va <= r_regs[r_in.src_a];
            r_vb <= r_regs[r_in.src_b];
        end
        if (r_state == S_EXEC) r_vl <= r_regs[rmis_pkg::LinkReg];
        if (r_state == S_EXEC) r_mul <= r_va * r_vb;
        if (o_ready && i_valid) r_in <= i_item;
        if (r_state == S_DONE && n_state == S_IDLE) begin
            r_out.next_pc <= w_npc;
            r_out.reg_written <= w_wr;
            r_out.written_reg <= w_wreg;
            r_out.written_value <= w_wval;
            r_out.div_zero <= w_dz;
            r_out.mem_error <= w_me;
            r_out.cycle_total <= r_cyc + 32'(r_in.cycle_cost);
            r_out.instr_total <= r_ins + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_pc <= '0;
            r_cyc <= '0;
            r_ins <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_DONE && n_state == S_IDLE) begin
                r_pc <= w_npc;
                r_cyc <= r_cyc + 32'(r_in.cycle_cost);
                r_ins <= r_ins + 32'd1;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_item = r_out;

    // a new item is never taken while the clearing pass runs
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready) else $error("accept during clear");
    // every retired instruction bumps the count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && n_state == S_IDLE) |=> (r_ins == $past(r_ins) + 32'd1))
        else $error("instruction count slip");
    // divider only finishes while waiting on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV)) else $error("stray divider done");
endmodule
`default_nettype wire

// ===== tb/register_machine_instruction_step_top_tb.sv =====
// testbench for the instruction step block: predicted results checked item by item
`timescale 1ns / 100ps
`default_nettype none
module register_machine_instruction_step_top_tb;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    rmis_pkg::t_in_item i_item = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    rmis_pkg::t_out_item o_item;

    register_machine_instruction_step_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [31:0] pred_regs [0:rmis_pkg::NumRegs-1];
    logic [31:0] pred_store [0:rmis_pkg::MemWords-1];
    logic [11:0] pred_pc;
    logic [31:0] pred_cycles;
    logic [31:0] pred_instrs;

    rmis_pkg::t_out_item expected_results [$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_req = 0;
    int hold_off_seen = 0;
    int hold_off_left = 0;

    // works out the result of one instruction and updates the predictor state
    function automatic rmis_pkg::t_out_item execute_instr(rmis_pkg::t_in_item it);
        rmis_pkg::t_out_item r;
        logic [31:0] va, vb, pc1, mag, q;
        logic signed [63:0] addr;
        logic addr_ok;
        rmis_pkg::t_opcode op;
        r = '0;
        op = rmis_pkg::t_opcode'(it.opcode);
        va = pred_regs[it.src_a];
        vb = pred_regs[it.src_b];
        pc1 = {20'd0, pred_pc + 12'd1};
        r.next_pc = pc1[11:0];
        addr = 64'(it.imm_b) + 64'(it.imm_a) + 64'(rmis_pkg::DataBase);
        addr_ok = (addr >= 0) && (addr < 64'(rmis_pkg::MemWords));
        case (op)
            rmis_pkg::OP_ADD: begin r.reg_written = 1'b1; r.written_value = va + vb; end
            rmis_pkg::OP_SUB: begin r.reg_written = 1'b1; r.written_value = va - vb; end
            rmis_pkg::OP_MULT: begin r.reg_written = 1'b1; r.written_value = va * vb; end
            rmis_pkg::OP_DIV: begin
                r.reg_written = 1'b1;
                if (vb == 0) begin
                    r.div_zero = 1'b1;
                end else begin
                    // magnitudes divided, sign applied after: truncates toward zero
                    mag = va[31] ? -va : va;
                    q = mag / (vb[31] ? -vb : vb);
                    r.written_value = (va[31] != vb[31]) ? -q : q;
                end
            end
            rmis_pkg::OP_BEQ: if (va == vb) r.next_pc = pc1[11:0] + it.imm_a[11:0];
            rmis_pkg::OP_BNE: if (va != vb) r.next_pc = pc1[11:0] + it.imm_a[11:0];
            rmis_pkg::OP_BLEZ:
                if ($signed(va) <= 0) r.next_pc = pc1[11:0] + it.imm_a[11:0];
            rmis_pkg::OP_BGTZ:
                if ($signed(va) > 0) r.next_pc = pc1[11:0] + it.imm_a[11:0];
            rmis_pkg::OP_J: r.next_pc = it.imm_a[11:0];
            rmis_pkg::OP_JAL: begin
                r.reg_written = 1'b1;
                r.written_value = pc1;
                r.next_pc = it.imm_a[11:0];
            end
            rmis_pkg::OP_JR: r.next_pc = pred_regs[rmis_pkg::LinkReg][11:0];
            rmis_pkg::OP_LW: begin
                if (addr_ok) begin
                    r.reg_written = 1'b1;
                    r.written_value = pred_store[addr[11:0]];
                end else r.mem_error = 1'b1;
            end
            rmis_pkg::OP_SW: begin
                if (addr_ok) pred_store[addr[11:0]] = va;
                else r.mem_error = 1'b1;
            end
            rmis_pkg::OP_LI: begin r.reg_written = 1'b1; r.written_value = it.imm_a; end
            rmis_pkg::OP_SRL: begin
                r.reg_written = 1'b1;
                mag = va[31] ? -va : va;
                r.written_value = va[31] ? -(mag >> it.shift_amount)
                                         : (va >> it.shift_amount);
            end
            default: begin
                r.reg_written = 1'b1;
                r.written_value = va << it.shift_amount;
            end
        endcase
        if (r.reg_written) begin
            r.written_reg = (op == rmis_pkg::OP_JAL) ? rmis_pkg::LinkReg : it.dest_reg;
            pred_regs[r.written_reg] = r.written_value;
        end
        pred_pc = r.next_pc;
        pred_cycles = pred_cycles + 32'(it.cycle_cost);
        pred_instrs = pred_instrs + 32'd1;
        r.cycle_total = pred_cycles;
        r.instr_total = pred_instrs;
        return r;
    endfunction

    // offers one item, with a random idle gap first, and waits for acceptance
    task automatic send_item(rmis_pkg::t_in_item it);
        rmis_pkg::t_out_item exp_r;
        do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (!o_ready);
        exp_r = execute_instr(it);
        expected_results = {expected_results, exp_r};
        i_valid <= 1'b0;
    endtask

    // receiver ready: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off_req != hold_off_seen) begin
            hold_off_seen <= hold_off_req;
            hold_off_left <= 300;
            i_ready <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        rmis_pkg::t_out_item exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_item);
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r !== o_item) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, o_item);
                end
            end
        end
    end

    function automatic rmis_pkg::t_in_item make_instr(rmis_pkg::t_opcode op, int rd, int ra,
                                                      int rb, logic [31:0] ia,
                                                      logic [31:0] ib, int sh);
        rmis_pkg::t_in_item it;
        it.opcode = op;
        it.dest_reg = 5'(rd);
        it.src_a = 5'(ra);
        it.src_b = 5'(rb);
        it.imm_a = ia;
        it.imm_b = ib;
        it.shift_amount = 5'(sh);
        it.cycle_cost = 8'($urandom_range(255));
        return it;
    endfunction

    // random item; mostly small registers and in-range addresses
    function automatic rmis_pkg::t_in_item random_instr();
        rmis_pkg::t_in_item it;
        it = rmis_pkg::t_in_item'({$urandom, $urandom, $urandom});
        if ($urandom_range(3) != 0) begin
            it.src_a = 5'($urandom_range(7));
            it.src_b = 5'($urandom_range(7));
            it.dest_reg = 5'($urandom_range(7));
        end
        if (it.opcode inside {rmis_pkg::OP_LW, rmis_pkg::OP_SW} && $urandom_range(4) != 0)
        begin
            it.imm_b = $urandom_range(40) - 20;
            it.imm_a = $urandom_range(rmis_pkg::MemWords - 1) - rmis_pkg::DataBase
                       - it.imm_b;
            if ($urandom_range(3) == 0) it.imm_a = $urandom_range(20) - rmis_pkg::DataBase;
        end else if ($urandom_range(2) == 0) begin
            it.imm_a = $urandom_range(64) - 32;
        end
        return it;
    endfunction

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // extremes of arithmetic, division corners, branches, jumps, memory bounds
    task automatic test_directed();
        send_item(make_instr(rmis_pkg::OP_LI, 1, 0, 0, 32'h8000_0000, 0, 0));
        send_item(make_instr(rmis_pkg::OP_LI, 2, 0, 0, 32'hFFFF_FFFF, 0, 0));
        send_item(make_instr(rmis_pkg::OP_LI, 3, 0, 0, 32'h7FFF_FFFF, 0, 0));
        send_item(make_instr(rmis_pkg::OP_DIV, 4, 1, 2, 0, 0, 0));   // most negative by -1
        send_item(make_instr(rmis_pkg::OP_DIV, 5, 3, 6, 0, 0, 0));   // zero divisor
        send_item(make_instr(rmis_pkg::OP_LI, 6, 0, 0, -7, 0, 0));
        send_item(make_instr(rmis_pkg::OP_LI, 7, 0, 0, 2, 0, 0));
        send_item(make_instr(rmis_pkg::OP_DIV, 8, 6, 7, 0, 0, 0));   // -7/2 truncates
        send_item(make_instr(rmis_pkg::OP_ADD, 9, 3, 3, 0, 0, 0));
        send_item(make_instr(rmis_pkg::OP_SUB, 10, 1, 7, 0, 0, 0));
        send_item(make_instr(rmis_pkg::OP_MULT, 11, 3, 3, 0, 0, 0));
        send_item(make_instr(rmis_pkg::OP_SRL, 12, 6, 0, 0, 0, 1));  // negative shift right
        send_item(make_instr(rmis_pkg::OP_SLL, 13, 2, 0, 0, 0, 31));
        send_item(make_instr(rmis_pkg::OP_BEQ, 0, 0, 31, 5, 0, 0));
        send_item(make_instr(rmis_pkg::OP_BNE, 0, 6, 7, -10, 0, 0));
        send_item(make_instr(rmis_pkg::OP_BLEZ, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
        send_item(make_instr(rmis_pkg::OP_BGTZ, 0, 3, 0, 3, 0, 0));
        send_item(make_instr(rmis_pkg::OP_JAL, 0, 0, 0, 32'hFFFF_FFFF, 0, 0)); // jump to the top pc
        send_item(make_instr(rmis_pkg::OP_J, 0, 0, 0, 100, 0, 0));
        send_item(make_instr(rmis_pkg::OP_JR, 0, 0, 0, 0, 0, 0));
        send_item(make_instr(rmis_pkg::OP_SW, 0, 1, 0, 3094, 1, 0));  // last word
        send_item(make_instr(rmis_pkg::OP_LW, 14, 0, 0, 3096, 0, 0)); // one past the end
        send_item(make_instr(rmis_pkg::OP_LW, 15, 0, 0, -1000, 0, 0)); // word zero, unwritten
        send_item(make_instr(rmis_pkg::OP_SW, 0, 2, 0, 32'h8000_0000, 32'h8000_0000, 0));
        send_item(make_instr(rmis_pkg::OP_LW, 16, 0, 0, 3094, 1, 0));
        wait_drained();
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_item(random_instr());
        wait_drained();
    endtask

    // receiver held off while the sender keeps offering, then a full pause
    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_off_req <= hold_off_req + 1;
        repeat (20) send_item(random_instr());
        wait_drained();
        repeat (10) send_item(random_instr());
        wait_drained();
    endtask

    initial begin
        for (int k = 0; k < rmis_pkg::NumRegs; k++) pred_regs[k] = '0;
        for (int k = 0; k < rmis_pkg::MemWords; k++) pred_store[k] = '0;
        pred_pc = '0;
        pred_cycles = '0;
        pred_instrs = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(150, 0, 0);
        test_random(110, 80, 0);
        test_random(110, 0, 80);
        test_random(130, 25, 25);
        test_back_pressure();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/rmis_pkg.sv
rtl/rmis_div.sv
rtl/register_machine_instruction_step_top.sv
tb/register_machine_instruction_step_top_tb.sv
